// File: hdl/dfl_pkg.sv
// Shared constants and codes for the descriptor index free list.
package dfl_pkg;

  localparam int MAX_SLOTS_DEF = 1024;

  localparam int SLOT_COUNT_W = 11;
  localparam int STRIDE_W     = 13;
  localparam int ADDR_W       = 64;
  localparam int INDEX_OUT_W  = 10;
  localparam int CFG_INDEX_W  = 2;

  localparam logic [SLOT_COUNT_W-1:0] SLOT_COUNT_RST = 11'd1024;
  localparam logic [STRIDE_W-1:0]     STRIDE_RST     = 13'd32;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_MISMATCH = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SLOT_COUNT = 2'd0,
    CFG_CPU_BASE   = 2'd1,
    CFG_GPU_BASE   = 2'd2,
    CFG_STRIDE     = 2'd3
  } cfg_index_t;

endpackage

// File: hdl/descriptor_index_free_list.sv
// Descriptor slot allocator with a free-index stack and a shared add/subtract unit.
//
//  channel   handshake             payload
//  command   start / busy          op, cpu_address_in, gpu_address_in
//  result    done (one cycle)      status, cpu_address_out, gpu_address_out, slot_index
//  config    cfg_valid / cfg_ready cfg_index, cfg_data
//
// Alloc steps through S_MUL, S_ADDC and S_ADDG before done; clear and failed allocs
// raise done straight from idle. Free runs S_MUL, then S_SUB, S_CHK and S_DIV per channel;
// the restoring divider shares the 64-bit adder with the range check and address math.
// Init writes one stack entry per cycle in S_FILL until every effective slot is on the stack.
// Reset is synchronous; the stack memory is not cleared and no pass runs after reset.
// The receiver cannot stall: each result is valid only while done is high.
module descriptor_index_free_list #(
  parameter int MAX_SLOTS = dfl_pkg::MAX_SLOTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           op,
  input  logic [dfl_pkg::ADDR_W-1:0]           cpu_address_in,
  input  logic [dfl_pkg::ADDR_W-1:0]           gpu_address_in,
  output logic                                 done,
  output logic [1:0]                           status,
  output logic [dfl_pkg::ADDR_W-1:0]           cpu_address_out,
  output logic [dfl_pkg::ADDR_W-1:0]           gpu_address_out,
  output logic [dfl_pkg::INDEX_OUT_W-1:0]      slot_index,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dfl_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [dfl_pkg::ADDR_W-1:0]           cfg_data
);

  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int QW = $clog2(MAX_SLOTS);
  localparam int SW = $clog2(QW + 1);
  localparam int PW = CW + dfl_pkg::STRIDE_W;
  localparam int DW = dfl_pkg::STRIDE_W + QW;
  localparam int NW = (CW > dfl_pkg::SLOT_COUNT_W) ? CW : dfl_pkg::SLOT_COUNT_W;
  localparam int AW = dfl_pkg::ADDR_W;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_FILL = 8'b0000_0010,
    S_MUL  = 8'b0000_0100,
    S_ADDC = 8'b0000_1000,
    S_ADDG = 8'b0001_0000,
    S_SUB  = 8'b0010_0000,
    S_CHK  = 8'b0100_0000,
    S_DIV  = 8'b1000_0000
  } state_t;

  state_t state;

  logic [dfl_pkg::SLOT_COUNT_W-1:0] slot_count;
  logic [AW-1:0]                    cpu_base;
  logic [AW-1:0]                    gpu_base;
  logic [dfl_pkg::STRIDE_W-1:0]     slot_stride;

  logic [CW-1:0] free_count;
  logic [QW-1:0] stack_mem [MAX_SLOTS];
  logic [QW-1:0] rd_data;
  logic [QW-1:0] rd_addr;
  logic [CW-1:0] fc_dec;
  logic          mem_we;
  logic [QW-1:0] mem_waddr;
  logic [QW-1:0] mem_wdata;

  logic [1:0]    op_q;
  logic [AW-1:0] lat_cpu;
  logic [AW-1:0] lat_gpu;
  logic          chan;
  logic [PW-1:0] prod;
  logic [QW-1:0] idx;
  logic [AW-1:0] rem;
  logic [DW-1:0] dsr;
  logic [SW-1:0] steps;
  logic [QW-1:0] q;
  logic [QW-1:0] qc;
  logic [QW-1:0] q_new;
  logic [QW-1:0] fp;
  logic [QW-1:0] fv;

  logic [CW-1:0]                n_eff;
  logic [dfl_pkg::STRIDE_W-1:0] stride_eff;
  logic [CW-1:0]                mul_a;

  logic [AW-1:0] add_a;
  logic [AW-1:0] add_b;
  logic          add_sub;
  logic [AW-1:0] add_sum;
  logic          add_co;

  logic accept;

  assign accept    = start && (state == S_IDLE);
  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    if (NW'(slot_count) > NW'(MAX_SLOTS)) begin
      n_eff = CW'(MAX_SLOTS);
    end else begin
      n_eff = CW'(slot_count);
    end
    stride_eff = (slot_stride == '0) ? dfl_pkg::STRIDE_W'(1) : slot_stride;
    mul_a      = (op_q == dfl_pkg::OP_ALLOC) ? CW'(rd_data) : n_eff;
  end

  always_comb begin
    add_a   = rem;
    add_b   = AW'(dsr);
    add_sub = 1'b1;
    case (state)
      S_ADDC: begin
        add_a   = AW'(prod);
        add_b   = cpu_base;
        add_sub = 1'b0;
      end
      S_ADDG: begin
        add_a   = AW'(prod);
        add_b   = gpu_base;
        add_sub = 1'b0;
      end
      S_SUB: begin
        add_a = chan ? lat_gpu : lat_cpu;
        add_b = chan ? gpu_base : cpu_base;
      end
      S_CHK: begin
        add_b = AW'(prod);
      end
      default: begin
        add_b = AW'(dsr);
      end
    endcase
    {add_co, add_sum} = {1'b0, add_a} + {1'b0, add_sub ? ~add_b : add_b} + (AW + 1)'(add_sub);
  end

  assign q_new  = QW'({q, add_co});
  assign fc_dec = free_count - CW'(1);
  assign rd_addr = fc_dec[QW-1:0];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = fp;
    mem_wdata = fv;
    if (state == S_FILL) begin
      mem_we = 1'b1;
    end else if (state == S_DIV && steps == SW'(1) && chan && qc == q_new &&
                 CW'(q_new) < n_eff && free_count < n_eff) begin
      mem_we    = 1'b1;
      mem_waddr = free_count[QW-1:0];
      mem_wdata = q_new;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count  <= dfl_pkg::SLOT_COUNT_RST;
      cpu_base    <= '0;
      gpu_base    <= '0;
      slot_stride <= dfl_pkg::STRIDE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dfl_pkg::CFG_SLOT_COUNT: slot_count  <= cfg_data[dfl_pkg::SLOT_COUNT_W-1:0];
        dfl_pkg::CFG_CPU_BASE:   cpu_base    <= cfg_data;
        dfl_pkg::CFG_GPU_BASE:   gpu_base    <= cfg_data;
        dfl_pkg::CFG_STRIDE:     slot_stride <= cfg_data[dfl_pkg::STRIDE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      free_count <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_q            <= op;
            lat_cpu         <= cpu_address_in;
            lat_gpu         <= gpu_address_in;
            chan            <= 1'b0;
            status          <= dfl_pkg::ST_OK;
            cpu_address_out <= '0;
            gpu_address_out <= '0;
            slot_index      <= '0;
            case (op)
              dfl_pkg::OP_INIT: begin
                free_count <= n_eff;
                fp         <= '0;
                fv         <= QW'(n_eff - CW'(1));
                if (n_eff == '0) begin
                  done <= 1'b1;
                end else begin
                  state <= S_FILL;
                end
              end
              dfl_pkg::OP_ALLOC: begin
                if (free_count == '0) begin
                  status <= dfl_pkg::ST_EMPTY;
                  done   <= 1'b1;
                end else begin
                  free_count <= fc_dec;
                  state      <= S_MUL;
                end
              end
              dfl_pkg::OP_FREE: begin
                state <= S_MUL;
              end
              default: begin
                free_count <= '0;
                done       <= 1'b1;
              end
            endcase
          end
        end
        S_FILL: begin
          fp <= fp + QW'(1);
          fv <= fv - QW'(1);
          if (fv == '0) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        S_MUL: begin
          prod <= PW'(mul_a) * PW'(stride_eff);
          idx  <= rd_data;
          if (op_q == dfl_pkg::OP_ALLOC) begin
            state <= S_ADDC;
          end else begin
            state <= S_SUB;
          end
        end
        S_ADDC: begin
          cpu_address_out <= add_sum;
          state           <= S_ADDG;
        end
        S_ADDG: begin
          gpu_address_out <= add_sum;
          slot_index      <= dfl_pkg::INDEX_OUT_W'(idx);
          state           <= S_IDLE;
          done            <= 1'b1;
        end
        S_SUB: begin
          rem   <= add_sum;
          state <= S_CHK;
        end
        S_CHK: begin
          if (!add_co) begin
            dsr   <= DW'(stride_eff) << (QW - 1);
            steps <= SW'(QW);
            q     <= '0;
            state <= S_DIV;
          end else begin
            status <= dfl_pkg::ST_MISMATCH;
            state  <= S_IDLE;
            done   <= 1'b1;
          end
        end
        S_DIV: begin
          if (add_co) begin
            rem <= add_sum;
          end
          q     <= q_new;
          dsr   <= dsr >> 1;
          steps <= steps - SW'(1);
          if (steps == SW'(1)) begin
            if (!chan) begin
              qc    <= q_new;
              chan  <= 1'b1;
              state <= S_SUB;
            end else begin
              state <= S_IDLE;
              done  <= 1'b1;
              if (qc != q_new) begin
                status <= dfl_pkg::ST_MISMATCH;
              end else if (free_count >= n_eff) begin
                status <= dfl_pkg::ST_FULL;
              end else begin
                free_count <= free_count + CW'(1);
                slot_index <= dfl_pkg::INDEX_OUT_W'(q_new);
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) || $past(start))
    else $error("result strobe without a command in progress");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done)
    else $error("accepted command neither started nor finished");

  a_count_idle_stable: assert property (@(posedge clk) disable iff (rst)
    !busy && !start |=> $stable(free_count))
    else $error("free count changed while idle");

  a_fail_zero_out: assert property (@(posedge clk) disable iff (rst)
    done && status != dfl_pkg::ST_OK |-> slot_index == '0 && cpu_address_out == '0 &&
      gpu_address_out == '0)
    else $error("failed command returned a nonzero slot");

endmodule

// File: tb/free_list_checker.sv
// Checker for the descriptor free list: predicts every result and compares it on arrival.
module free_list_checker #(
  parameter int MAX_SLOTS = dfl_pkg::MAX_SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic                               busy,
  input  logic [1:0]                         op,
  input  logic [dfl_pkg::ADDR_W-1:0]         cpu_address_in,
  input  logic [dfl_pkg::ADDR_W-1:0]         gpu_address_in,
  input  logic                               done,
  input  logic [1:0]                         status,
  input  logic [dfl_pkg::ADDR_W-1:0]         cpu_address_out,
  input  logic [dfl_pkg::ADDR_W-1:0]         gpu_address_out,
  input  logic [dfl_pkg::INDEX_OUT_W-1:0]    slot_index,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [dfl_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [dfl_pkg::ADDR_W-1:0]         cfg_data,
  output int                                 mismatches,
  output int                                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import dfl_pkg::*;

  typedef struct {
    status_t                 code;
    logic [ADDR_W-1:0]       cpu_addr;
    logic [ADDR_W-1:0]       gpu_addr;
    logic [INDEX_OUT_W-1:0]  slot;
  } slot_result_t;

  logic [SLOT_COUNT_W-1:0] slot_count_q;
  logic [ADDR_W-1:0]       cpu_base_q;
  logic [ADDR_W-1:0]       gpu_base_q;
  logic [STRIDE_W-1:0]     stride_q;

  int unsigned   free_stack [MAX_SLOTS];
  int unsigned   free_depth;
  int            fail_count;
  slot_result_t  pending_results [$];
  slot_result_t  oldest;

  function automatic int unsigned live_slots();
    return (slot_count_q > MAX_SLOTS) ? MAX_SLOTS : int'(slot_count_q);
  endfunction

  function automatic logic [ADDR_W-1:0] live_stride();
    return (stride_q == '0) ? 64'd1 : 64'(stride_q);
  endfunction

  task automatic report(string what);
    $display("%0t ns: %s", $realtime, what);
    fail_count++;
  endtask

  task automatic queue_result(slot_result_t r);
    pending_results = {pending_results, r};
  endtask

  function automatic slot_result_t predict_slot_result(op_t code, logic [ADDR_W-1:0] cpu_in,
                                                       logic [ADDR_W-1:0] gpu_in);
    slot_result_t      r;
    int unsigned       n;
    logic [ADDR_W-1:0] pitch;
    logic [ADDR_W-1:0] cpu_quot;
    logic [ADDR_W-1:0] gpu_quot;
    logic [ADDR_W-1:0] idx;
    r = '{ST_OK, '0, '0, '0};
    n = live_slots();
    pitch = live_stride();
    case (code)
      OP_INIT: begin
        for (int k = 0; k < n; k++) free_stack[k] = n - 1 - k;
        free_depth = n;
      end
      OP_ALLOC: begin
        if (free_depth == 0 || free_depth > MAX_SLOTS) begin
          r.code = ST_EMPTY;
        end else begin
          free_depth--;
          idx = 64'(free_stack[free_depth]);
          r.cpu_addr = cpu_base_q + idx * pitch;
          r.gpu_addr = gpu_base_q + idx * pitch;
          r.slot = idx[INDEX_OUT_W-1:0];
        end
      end
      OP_FREE: begin
        cpu_quot = (cpu_in - cpu_base_q) / pitch;
        gpu_quot = (gpu_in - gpu_base_q) / pitch;
        if (cpu_quot != gpu_quot || cpu_quot >= 64'(n)) begin
          r.code = ST_MISMATCH;
        end else if (free_depth >= n) begin
          r.code = ST_FULL;
        end else begin
          free_stack[free_depth] = cpu_quot[31:0];
          free_depth++;
          r.slot = cpu_quot[INDEX_OUT_W-1:0];
        end
      end
      default: begin
        free_depth = 0;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      slot_count_q = SLOT_COUNT_RST;
      cpu_base_q = '0;
      gpu_base_q = '0;
      stride_q = STRIDE_RST;
      free_depth = 0;
      pending_results.delete();
    end else begin
      if (done) begin
        if (pending_results.size() == 0) begin
          report($sformatf("result with nothing expected: status %0d slot %0d", status,
                           slot_index));
        end else begin
          oldest = pending_results.pop_front();
          if (status !== oldest.code) begin
            report($sformatf("status got %0d expected %s", status, oldest.code.name()));
          end
          if (cpu_address_out !== oldest.cpu_addr) begin
            report($sformatf("cpu_address_out got %h expected %h", cpu_address_out,
                             oldest.cpu_addr));
          end
          if (gpu_address_out !== oldest.gpu_addr) begin
            report($sformatf("gpu_address_out got %h expected %h", gpu_address_out,
                             oldest.gpu_addr));
          end
          if (slot_index !== oldest.slot) begin
            report($sformatf("slot_index got %0d expected %0d", slot_index, oldest.slot));
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index_t'(cfg_index))
          CFG_SLOT_COUNT: slot_count_q = cfg_data[SLOT_COUNT_W-1:0];
          CFG_CPU_BASE:   cpu_base_q = cfg_data;
          CFG_GPU_BASE:   gpu_base_q = cfg_data;
          CFG_STRIDE:     stride_q = cfg_data[STRIDE_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        queue_result(predict_slot_result(op_t'(op), cpu_address_in, gpu_address_in));
      end
    end
    outstanding <= pending_results.size();
    mismatches <= fail_count;
  end

endmodule

// File: tb/tb_top.sv
// Top of the free list testbench: clock, reset, command and register stimulus, verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dfl_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int ITEM_TARGET = 850;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic [1:0]              op = OP_INIT;
  logic [ADDR_W-1:0]       cpu_address_in = '0;
  logic [ADDR_W-1:0]       gpu_address_in = '0;
  logic                    cfg_valid = 1'b0;
  cfg_index_t              cfg_index = CFG_SLOT_COUNT;
  logic [ADDR_W-1:0]       cfg_data = '0;
  logic                    busy;
  logic                    done;
  logic [1:0]              status;
  logic [ADDR_W-1:0]       cpu_address_out;
  logic [ADDR_W-1:0]       gpu_address_out;
  logic [INDEX_OUT_W-1:0]  slot_index;
  logic                    cfg_ready;

  int fails;
  int outstanding;
  int stall_cycles = 0;
  int items_sent = 0;
  bit steady = 1'b0;

  logic [SLOT_COUNT_W-1:0] cur_count = SLOT_COUNT_RST;
  logic [ADDR_W-1:0]       cur_cbase = '0;
  logic [ADDR_W-1:0]       cur_gbase = '0;
  logic [STRIDE_W-1:0]     cur_stride = STRIDE_RST;

  always #2 clk = ~clk;

  descriptor_index_free_list #(.MAX_SLOTS(MAX_SLOTS_DEF)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .cpu_address_in(cpu_address_in), .gpu_address_in(gpu_address_in),
    .done(done), .status(status), .cpu_address_out(cpu_address_out),
    .gpu_address_out(gpu_address_out), .slot_index(slot_index),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  free_list_checker #(.MAX_SLOTS(MAX_SLOTS_DEF)) scoreboard (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .cpu_address_in(cpu_address_in), .gpu_address_in(gpu_address_in),
    .done(done), .status(status), .cpu_address_out(cpu_address_out),
    .gpu_address_out(gpu_address_out), .slot_index(slot_index),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .mismatches(fails), .outstanding(outstanding)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= IDLE_LIMIT) begin
      $display("FAIL descriptor_index_free_list");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [ADDR_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int unsigned span();
    return (cur_count > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : int'(cur_count);
  endfunction

  function automatic int unsigned pitch();
    return (cur_stride == '0) ? 1 : int'(cur_stride);
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(logic [ADDR_W-1:0] base, int unsigned idx);
    return base + 64'(idx) * 64'(pitch());
  endfunction

  task automatic send(op_t code, logic [ADDR_W-1:0] ca, logic [ADDR_W-1:0] ga);
    int g;
    start <= 1'b1;
    op <= code;
    cpu_address_in <= ca;
    gpu_address_in <= ga;
    do @(posedge clk); while (busy);
    items_sent++;
    g = 0;
    if (!steady) begin
      case ($urandom_range(0, 19))
        0, 1:       g = $urandom_range(8, 40);
        2, 3, 4, 5,
        6, 7, 8:    g = $urandom_range(1, 3);
        default:    g = 0;
      endcase
    end
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic free_slot(int unsigned idx);
    send(OP_FREE, slot_addr(cur_cbase, idx) + 64'($urandom_range(0, pitch() - 1)),
         slot_addr(cur_gbase, idx) + 64'($urandom_range(0, pitch() - 1)));
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || busy);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [ADDR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(logic [SLOT_COUNT_W-1:0] n, logic [ADDR_W-1:0] cb,
                            logic [ADDR_W-1:0] gb, logic [STRIDE_W-1:0] s);
    drain();
    write_reg(CFG_SLOT_COUNT, 64'(n));
    write_reg(CFG_CPU_BASE, cb);
    write_reg(CFG_GPU_BASE, gb);
    write_reg(CFG_STRIDE, 64'(s));
    cfg_valid <= 1'b0;
    cur_count = n;
    cur_cbase = cb;
    cur_gbase = gb;
    cur_stride = s;
  endtask

  function automatic logic [ADDR_W-1:0] pick_base();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return ~64'd0 - 64'($urandom_range(0, 4095));
      2:       return '1;
      default: return rand64();
    endcase
  endfunction

  task automatic new_phase();
    logic [SLOT_COUNT_W-1:0] n;
    logic [STRIDE_W-1:0]     s;
    case ($urandom_range(0, 9))
      0:       n = '0;
      1:       n = 11'd1024;
      2:       n = 11'd2047;
      3:       n = 11'($urandom_range(17, 1023));
      default: n = 11'($urandom_range(1, 16));
    endcase
    case ($urandom_range(0, 7))
      0:       s = '0;
      1:       s = 13'd1;
      2:       s = 13'd4096;
      3:       s = 13'd8191;
      4:       s = 13'($urandom_range(1, 8191));
      default: s = 13'($urandom_range(1, 64));
    endcase
    set_config(n, pick_base(), pick_base(), s);
    steady = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 4) != 0) begin
      send(OP_INIT, rand64(), rand64());
    end
  endtask

  task automatic random_item();
    int unsigned n;
    int unsigned i;
    int r;
    n = span();
    r = $urandom_range(0, 99);
    i = (n == 0) ? 0 : $urandom_range(0, n - 1);
    if (r < 42) begin
      send(OP_ALLOC, rand64(), rand64());
    end else if (r < 80) begin
      free_slot(i);
    end else if (r < 84) begin
      send(OP_FREE, slot_addr(cur_cbase, i),
           slot_addr(cur_gbase, i + $urandom_range(1, 3)));
    end else if (r < 88) begin
      free_slot(n + $urandom_range(0, 3));
    end else if (r < 91) begin
      send(OP_FREE, rand64(), rand64());
    end else if (r < 93) begin
      send(OP_FREE, cur_cbase - 64'($urandom_range(1, 100)),
           cur_gbase - 64'($urandom_range(1, 100)));
    end else if (r < 97) begin
      send(OP_INIT, rand64(), rand64());
    end else begin
      send(OP_CLEAR, rand64(), rand64());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Stack is empty after reset; a free may still push into it.
    send(OP_ALLOC, '0, '0);
    send(OP_FREE, '0, '0);
    send(OP_ALLOC, '1, '1);
    send(OP_CLEAR, '0, '0);

    // Zero stride with a host base that wraps past the top of the address space.
    set_config(11'd4, 64'hFFFF_FFFF_FFFF_FFFE, '0, '0);
    send(OP_INIT, '0, '0);
    send(OP_ALLOC, '0, '0);
    send(OP_ALLOC, '0, '0);
    free_slot(3);
    send(OP_FREE, slot_addr(cur_cbase, 1), slot_addr(cur_gbase, 2));
    send(OP_FREE, cur_cbase - 64'd1, cur_gbase);
    free_slot(4);
    send(OP_INIT, '1, '1);
    free_slot(2);
    send(OP_CLEAR, '0, '0);
    send(OP_ALLOC, '0, '0);

    // Oversized slot count is clamped to the table size.
    set_config(11'd2047, '0, '1, 13'd4096);
    send(OP_INIT, '0, '0);
    send(OP_ALLOC, '0, '0);
    free_slot(1023);
    send(OP_ALLOC, '0, '0);
    free_slot(1023);

    // An empty table rejects every alloc and free.
    set_config(11'd0, rand64(), rand64(), 13'd1);
    send(OP_INIT, '0, '0);
    send(OP_ALLOC, '0, '0);
    send(OP_FREE, cur_cbase, cur_gbase);

    while (items_sent < ITEM_TARGET) begin
      new_phase();
      repeat ($urandom_range(40, 90)) begin
        if ($urandom_range(0, 59) == 0) begin
          drain();
        end
        random_item();
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (fails == 0) begin
      $display("PASS descriptor_index_free_list");
    end else begin
      $display("FAIL descriptor_index_free_list");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/dfl_pkg.sv
hdl/descriptor_index_free_list.sv
tb/free_list_checker.sv
tb/tb_top.sv
